@@ design/lgi_pkg.sv @@
package lgi_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int TAG_W    = 8;
    localparam int PAIR_W   = SAMPLE_W + 1;   // sum or difference of two samples
    localparam int COEF_W   = 26;             // signed Q.24 coefficient constant
    localparam int TERM_W   = COEF_W + PAIR_W;
    localparam int CSUM_W   = TERM_W + 2;     // sum of three terms
    localparam int ACC_W    = 48;             // Horner accumulator, Q.24
    localparam int Q_SHIFT  = 24;             // fraction bits of the accumulator
    localparam int Z_SHIFT  = 16;             // z always held as Q0.16
    localparam int HI_W     = ACC_W - Q_SHIFT;
    localparam int PHI_W    = HI_W + FRAC_W;
    localparam int PLO_W    = Q_SHIFT + 1 + FRAC_W;
    localparam int N_STEPS  = 6;

    typedef logic signed [SAMPLE_W-1:0] lgi_sample_t;
    typedef logic signed [PAIR_W-1:0]   lgi_pair_t;
    typedef logic signed [COEF_W-1:0]   lgi_coef_val_t;
    typedef logic signed [ACC_W-1:0]    lgi_acc_t;
    typedef logic signed [FRAC_W-1:0]   lgi_z_t;

    // Input request
    typedef struct packed {
        lgi_sample_t        sample_m2;
        lgi_sample_t        sample_m1;
        lgi_sample_t        sample_0;
        lgi_sample_t        sample_p1;
        lgi_sample_t        sample_p2;
        lgi_sample_t        sample_p3;
        logic [FRAC_W-1:0]  frac_pos;
        logic [TAG_W-1:0]   channel_tag;
    } lgi_in_t;

    // Result
    typedef struct packed {
        lgi_sample_t        interp_sample;
        logic [TAG_W-1:0]   channel_out;
    } lgi_out_t;

    // Payload carried down the pipeline
    typedef struct packed {
        lgi_acc_t           acc;
        lgi_pair_t          e1;
        lgi_pair_t          e2;
        lgi_pair_t          e3;
        lgi_pair_t          o1;
        lgi_pair_t          o2;
        lgi_pair_t          o3;
        lgi_z_t             z;
        logic [TAG_W-1:0]   tag;
    } lgi_pipe_t;

    // One polynomial coefficient: k1*x1 + k2*x2 + k3*x3 over odd or even pairs
    typedef struct packed {
        logic               use_odd;
        lgi_coef_val_t      k1;
        lgi_coef_val_t      k2;
        lgi_coef_val_t      k3;
    } lgi_coef_t;

    // Coefficients c5 down to c0 in Horner order, value * 2^24 rounded to nearest
    localparam lgi_coef_t COEF [0:N_STEPS-1] = '{
        '{1'b1, -26'sd139810,   26'sd699051,   -26'sd1398101 },
        '{1'b0,  26'sd349525,  -26'sd1048576,   26'sd699051  },
        '{1'b1,  26'sd349525,  -26'sd4543829,   26'sd11883861},
        '{1'b0, -26'sd873813,   26'sd6815744,  -26'sd5941931 },
        '{1'b1, -26'sd78643,    26'sd1092267,  -26'sd19660800},
        '{1'b0,  26'sd196608,  -26'sd1638400,   26'sd9830400 }
    };

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

endpackage

@@ design/lgi_front.sv @@
module lgi_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lgi_pkg::lgi_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lgi_pkg::lgi_pipe_t out_data
);

    localparam int EFF_BITS = (FRAC_BITS < lgi_pkg::FRAC_W) ? FRAC_BITS : lgi_pkg::FRAC_W;
    localparam logic [lgi_pkg::FRAC_W-1:0] FRAC_MASK =
        lgi_pkg::FRAC_W'(~((32'd1 << (lgi_pkg::FRAC_W - EFF_BITS)) - 32'd1));

    logic               valid_reg;
    lgi_pkg::lgi_pipe_t data_reg;
    lgi_pkg::lgi_pipe_t data_next;
    logic [lgi_pkg::FRAC_W-1:0] frac_used;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Mirrored pair sums and differences; z = fraction - 1/2 kept in Q0.16
    always_comb begin
        frac_used      = in_data.frac_pos & FRAC_MASK;
        data_next.acc  = '0;
        data_next.e1   = lgi_pkg::PAIR_W'(in_data.sample_m2) + lgi_pkg::PAIR_W'(in_data.sample_p3);
        data_next.o1   = lgi_pkg::PAIR_W'(in_data.sample_m2) - lgi_pkg::PAIR_W'(in_data.sample_p3);
        data_next.e2   = lgi_pkg::PAIR_W'(in_data.sample_m1) + lgi_pkg::PAIR_W'(in_data.sample_p2);
        data_next.o2   = lgi_pkg::PAIR_W'(in_data.sample_m1) - lgi_pkg::PAIR_W'(in_data.sample_p2);
        data_next.e3   = lgi_pkg::PAIR_W'(in_data.sample_0) + lgi_pkg::PAIR_W'(in_data.sample_p1);
        data_next.o3   = lgi_pkg::PAIR_W'(in_data.sample_0) - lgi_pkg::PAIR_W'(in_data.sample_p1);
        data_next.z    = {~frac_used[lgi_pkg::FRAC_W-1], frac_used[lgi_pkg::FRAC_W-2:0]};
        data_next.tag  = in_data.channel_tag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/lgi_horner_step.sv @@
module lgi_horner_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  lgi_pkg::lgi_coef_t  coef,
    input  logic                in_valid,
    output logic                in_ready,
    input  lgi_pkg::lgi_pipe_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lgi_pkg::lgi_pipe_t  out_data
);

    // Stage A: partial products of acc * z and the coefficient sum
    logic                           a_valid_reg;
    lgi_pkg::lgi_pipe_t             a_pipe_reg;
    logic signed [lgi_pkg::PHI_W-1:0]  a_phi_reg;
    logic signed [lgi_pkg::PLO_W-1:0]  a_plo_reg;
    logic signed [lgi_pkg::CSUM_W-1:0] a_c_reg;
    logic                           a_ready;

    logic signed [lgi_pkg::HI_W-1:0]   acc_hi;
    logic signed [lgi_pkg::Q_SHIFT:0]  acc_lo;
    logic signed [lgi_pkg::PHI_W-1:0]  phi_next;
    logic signed [lgi_pkg::PLO_W-1:0]  plo_next;
    lgi_pkg::lgi_pair_t                x1;
    lgi_pkg::lgi_pair_t                x2;
    lgi_pkg::lgi_pair_t                x3;
    logic signed [lgi_pkg::TERM_W-1:0] t1;
    logic signed [lgi_pkg::TERM_W-1:0] t2;
    logic signed [lgi_pkg::TERM_W-1:0] t3;
    logic signed [lgi_pkg::CSUM_W-1:0] c_next;

    // Stage B: recombine, floor by 2^16, add coefficient
    logic                b_valid_reg;
    lgi_pkg::lgi_pipe_t  b_pipe_reg;
    lgi_pkg::lgi_pipe_t  b_pipe_next;

    always_comb begin
        acc_hi   = in_data.acc[lgi_pkg::ACC_W-1:lgi_pkg::Q_SHIFT];
        acc_lo   = {1'b0, in_data.acc[lgi_pkg::Q_SHIFT-1:0]};
        phi_next = lgi_pkg::PHI_W'(acc_hi) * lgi_pkg::PHI_W'(in_data.z);
        plo_next = lgi_pkg::PLO_W'(acc_lo) * lgi_pkg::PLO_W'(in_data.z);
        x1       = coef.use_odd ? in_data.o1 : in_data.e1;
        x2       = coef.use_odd ? in_data.o2 : in_data.e2;
        x3       = coef.use_odd ? in_data.o3 : in_data.e3;
        t1       = lgi_pkg::TERM_W'(coef.k1) * lgi_pkg::TERM_W'(x1);
        t2       = lgi_pkg::TERM_W'(coef.k2) * lgi_pkg::TERM_W'(x2);
        t3       = lgi_pkg::TERM_W'(coef.k3) * lgi_pkg::TERM_W'(x3);
        c_next   = lgi_pkg::CSUM_W'(t1) + lgi_pkg::CSUM_W'(t2) + lgi_pkg::CSUM_W'(t3);
    end

    // floor(acc*z / 2^16) = p_hi*2^8 + floor(p_lo / 2^16)
    always_comb begin
        b_pipe_next     = a_pipe_reg;
        b_pipe_next.acc = (lgi_pkg::ACC_W'(a_phi_reg) <<< (lgi_pkg::Q_SHIFT - lgi_pkg::Z_SHIFT))
                        + lgi_pkg::ACC_W'(a_plo_reg >>> lgi_pkg::Z_SHIFT)
                        + lgi_pkg::ACC_W'(a_c_reg);
    end

    assign a_ready   = !b_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || a_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_pipe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                a_valid_reg <= in_valid;
            end
            if (a_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_pipe_reg <= in_data;
            a_phi_reg  <= phi_next;
            a_plo_reg  <= plo_next;
            a_c_reg    <= c_next;
        end
        if (a_ready && a_valid_reg) begin
            b_pipe_reg <= b_pipe_next;
        end
    end

endmodule

@@ design/lgi_output.sv @@
module lgi_output (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lgi_pkg::lgi_pipe_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lgi_pkg::lgi_out_t   out_data
);

    logic               valid_reg;
    lgi_pkg::lgi_out_t  data_reg;
    lgi_pkg::lgi_out_t  data_next;
    logic signed [lgi_pkg::HI_W:0] q;
    logic               round_up;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Truncate Q.24 toward zero, then saturate to 16 bits
    always_comb begin
        round_up = in_data.acc[lgi_pkg::ACC_W-1] && (|in_data.acc[lgi_pkg::Q_SHIFT-1:0]);
        q        = {in_data.acc[lgi_pkg::ACC_W-1], in_data.acc[lgi_pkg::ACC_W-1:lgi_pkg::Q_SHIFT]}
                 + (lgi_pkg::HI_W+1)'(round_up);
        if (q > (lgi_pkg::HI_W+1)'(lgi_pkg::SAT_MAX)) begin
            data_next.interp_sample = lgi_pkg::SAMPLE_W'(lgi_pkg::SAT_MAX);
        end else if (q < (lgi_pkg::HI_W+1)'(lgi_pkg::SAT_MIN)) begin
            data_next.interp_sample = lgi_pkg::SAMPLE_W'(lgi_pkg::SAT_MIN);
        end else begin
            data_next.interp_sample = q[lgi_pkg::SAMPLE_W-1:0];
        end
        data_next.channel_out = in_data.tag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/six_point_lagrange_interpolator.sv @@
// Six-point fifth-order Lagrange interpolator. Each request carries six
// neighbouring samples, a Q0.16 fraction and a channel tag; each result is the
// interpolated sample (Q.24 datapath, truncated toward zero, saturated to
// 16 bits) with the tag copied across. One request is accepted every clock
// unless a stall reaches the front stage, which registers the mirrored pair
// sums. Each of the six Horner steps has a partial-product stage (split acc*z
// partial products) and a recombine and coefficient-add stage, and the last
// stage rounds and saturates. Every stage has its own valid bit and fills
// bubbles on a stall, so the request side keeps accepting while a result
// waits for m_ready until all 14 stages hold data. FRAC_BITS sets how many
// top bits of frac_pos are used (8 to 16; larger values behave as 16).
module six_point_lagrange_interpolator #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lgi_pkg::lgi_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lgi_pkg::lgi_out_t  m_data
);

    logic               pipe_valid [0:lgi_pkg::N_STEPS];
    logic               pipe_ready [0:lgi_pkg::N_STEPS];
    lgi_pkg::lgi_pipe_t pipe_data  [0:lgi_pkg::N_STEPS];

    // Pair sums and z
    lgi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .out_data  (pipe_data[0])
    );

    // Horner chain, c5 first with a zero accumulator
    for (genvar i = 0; i < lgi_pkg::N_STEPS; i++) begin : g_step
        lgi_horner_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .coef      (lgi_pkg::COEF[i]),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    // Rounding, saturation and result register
    lgi_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pipe_valid[lgi_pkg::N_STEPS]),
        .in_ready  (pipe_ready[lgi_pkg::N_STEPS]),
        .in_data   (pipe_data[lgi_pkg::N_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef ASSERT_OFF
    // An empty result register frees every stage, so a request must be taken
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request side stalled with empty result register");

    // A stalled item at the last Horner stage holds its value
    a_last_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid[lgi_pkg::N_STEPS] && !pipe_ready[lgi_pkg::N_STEPS] |=>
        pipe_valid[lgi_pkg::N_STEPS] && $stable(pipe_data[lgi_pkg::N_STEPS]))
        else $error("last Horner stage lost or changed a stalled item");

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
